### rtl/swdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdm_pkg
// Shared types, glyph tables and helpers for the weighted display multiplexer.
// ----------------------------------------------------------------------------
package swdm_pkg;

  localparam int NUM_DIGITS = 3;
  localparam int SLOT_W     = 2;
  localparam int CODE_W     = 8;
  localparam int SEG_W      = 8;
  localparam int DWELL_W    = 8;
  localparam int CNT_W      = 4;
  localparam int VALUE_W    = 16;

  localparam logic [CODE_W-1:0] BLANK_CODE  = 8'h20;
  localparam logic [CODE_W-1:0] LETTER_BASE = 8'h61;
  localparam logic [CODE_W-1:0] LETTER_LAST = 8'h7A;
  localparam logic [CODE_W-1:0] DIGIT_LAST  = 8'h09;
  localparam logic [VALUE_W-1:0] MAX_VALUE  = 16'd999;

  localparam logic [SEG_W-1:0] DIGIT_GLYPHS [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h73
  };

  localparam logic [SEG_W-1:0] LETTER_GLYPHS [26] = '{
    8'h7D, 8'h1F, 8'h0D, 8'h3D, 8'h6F, 8'h47, 8'h7B, 8'h17, 8'h30, 8'h3C,
    8'h57, 8'h0E, 8'h55, 8'h15, 8'h1D, 8'h67, 8'hF3, 8'h05, 8'h5B, 8'h0F,
    8'h1C, 8'h1C, 8'h5C, 8'h37, 8'h3B, 8'h6D
  };

  typedef struct packed {
    logic             ok;
    logic [SEG_W-1:0] pattern;
  } glyph_t;

  // Multiplexer state; also what the result channel shows.
  typedef struct packed {
    logic [SEG_W-1:0]      anode;
    logic [NUM_DIGITS-1:0] cathode;
    logic [SLOT_W-1:0]     slot;
    logic [DWELL_W-1:0]    dwell;
  } disp_state_t;

  function automatic glyph_t glyph_pattern(input logic [CODE_W-1:0] code);
    glyph_t             g;
    logic [CODE_W-1:0]  ofs;
    g   = '0;
    ofs = code - LETTER_BASE;
    if (code <= DIGIT_LAST) begin
      g.ok      = 1'b1;
      g.pattern = DIGIT_GLYPHS[code[3:0]];
    end else if (code >= LETTER_BASE && code <= LETTER_LAST) begin
      g.ok      = 1'b1;
      g.pattern = LETTER_GLYPHS[ofs[4:0]];
    end
    return g;
  endfunction

  // Lit segments of a glyph; codes without a glyph count as zero.
  function automatic logic [CNT_W-1:0] lit_count(input glyph_t g);
    logic [CNT_W-1:0] n;
    n = '0;
    if (g.ok) begin
      for (int i = 0; i < SEG_W; i++) begin
        n = n + CNT_W'(g.pattern[i]);
      end
    end
    return n;
  endfunction

endpackage

### rtl/swdm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdm_in_if / swdm_out_if
// Valid/ready channels for display ticks and multiplexer results.
// ----------------------------------------------------------------------------
interface swdm_in_if;
  logic        valid;
  logic        ready;
  logic        show_number;
  logic [15:0] number_value;

  modport source (output valid, output show_number, output number_value, input ready);
  modport sink   (input valid, input show_number, input number_value, output ready);
endinterface

interface swdm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] anode_pattern;
  logic [2:0] digit_enable;
  logic [1:0] active_slot;

  modport source (output valid, output anode_pattern, output digit_enable,
                  output active_slot, input ready);
  modport sink   (input valid, input anode_pattern, input digit_enable,
                  input active_slot, output ready);
endinterface

### rtl/swdm_digit_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdm_digit_split
// Splits a value up to 999 into glyph codes with leading-zero blanking.
// ----------------------------------------------------------------------------
module swdm_digit_split (
  input  logic [swdm_pkg::VALUE_W-1:0] value,
  output logic                         in_range,
  output logic [swdm_pkg::CODE_W-1:0]  codes [swdm_pkg::NUM_DIGITS]
);
  import swdm_pkg::*;

  logic [9:0]  v10;
  logic [15:0] prod_h;   // v * 41,  >> 12 gives v / 100 for v < 1000
  logic [17:0] prod_t;   // v * 205, >> 11 gives v / 10  for v < 1000
  logic [3:0]  hund;
  logic [6:0]  tens_all;
  logic [6:0]  tens_w;
  logic [9:0]  ones_w;

  assign v10      = value[9:0];
  assign in_range = (value <= MAX_VALUE);

  assign prod_h   = {6'd0, v10} * 16'd41;
  assign prod_t   = {8'd0, v10} * 18'd205;
  assign hund     = prod_h[15:12];
  assign tens_all = prod_t[17:11];
  assign tens_w   = tens_all - 7'({3'd0, hund} * 7'd10);
  assign ones_w   = v10 - 10'({3'd0, tens_all} * 10'd10);

  assign codes[0] = (value >= 16'd100) ? {4'd0, hund} : BLANK_CODE;
  assign codes[1] = (value >= 16'd10)  ? {4'd0, tens_w[3:0]} : BLANK_CODE;
  assign codes[2] = {4'd0, ones_w[3:0]};

endmodule

### rtl/swdm_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swdm_scan
// Dwell countdown and slot advance with blank skipping for one tick.
// ----------------------------------------------------------------------------
module swdm_scan (
  input  logic [swdm_pkg::CODE_W-1:0] codes [swdm_pkg::NUM_DIGITS],
  input  swdm_pkg::disp_state_t       cur,
  output swdm_pkg::disp_state_t       nxt
);
  import swdm_pkg::*;

  glyph_t                 gl  [NUM_DIGITS];
  logic [CNT_W-1:0]       cnt [NUM_DIGITS];
  logic [DWELL_W-1:0]     dec;
  logic [SLOT_W-1:0]      slot_v;
  logic [NUM_DIGITS-1:0]  bitm;

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_glyph
    assign gl[g]  = glyph_pattern(codes[g]);
    assign cnt[g] = lit_count(gl[g]);
  end

  always_comb begin
    nxt       = cur;
    dec       = cur.dwell - DWELL_W'(1);
    nxt.dwell = dec;
    slot_v    = (cur.slot == SLOT_W'(NUM_DIGITS - 1)) ? '0 : cur.slot + SLOT_W'(1);
    bitm      = '0;
    if (dec == '0) begin
      // Walk forward from the next slot; a blank slot hands over to the one after.
      for (int s = 0; s < NUM_DIGITS; s++) begin
        bitm = NUM_DIGITS'(1) << s;
        if (slot_v == SLOT_W'(s)) begin
          if (cnt[s] == '0) begin
            nxt.cathode = nxt.cathode & ~bitm;
            if (s < NUM_DIGITS - 1) begin
              slot_v = SLOT_W'(s + 1);
            end else begin
              nxt.dwell = DWELL_W'(1);
            end
          end else begin
            nxt.anode   = gl[s].pattern;
            nxt.cathode = bitm;
            nxt.dwell   = DWELL_W'(cnt[s]);
          end
        end
      end
      nxt.slot = slot_v;
    end
  end

endmodule

### rtl/segment_weighted_display_mux.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_weighted_display_mux
// Three-digit seven-segment multiplexer with segment-count weighted dwell.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transfer per millisecond tick. show_number = 1 with a
//            number_value of at most 999 reloads the three digit slots
//            (leading zeros blanked); otherwise the slots are kept.
//   out_ch : one transfer per tick, carrying the segment drive
//            (anode_pattern), the slot cathodes (digit_enable) and the
//            selected slot (active_slot) after that tick.
//   Path:    a taken tick waits in the input register; the update logic then
//            writes the state register, which drives out_ch.
//   Throughput: one tick per cycle unless out_ch stalls; the update is a
//            single pass of short logic (digit split, glyph lookup,
//            popcount, slot walk).
//   Reset: all slots hold digit 0, slot 0 selected, anodes and cathodes
//            off, dwell zero, so the first slot change follows 256 ticks.
//   Stall: the state register doubles as the output register and is only
//            advanced when the result slot is free; the input register holds
//            one more tick, after which in_ch.ready drops.
// ----------------------------------------------------------------------------
module segment_weighted_display_mux (
  input  logic       clk,
  input  logic       rst_n,
  swdm_in_if.sink    in_ch,
  swdm_out_if.source out_ch
);
  import swdm_pkg::*;

  // Input register
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_show_r;
  logic [VALUE_W-1:0]  s1_value_r;

  // Display state / result register
  disp_state_t         st_r, st_nxt;
  logic [CODE_W-1:0]   glyph_r   [NUM_DIGITS];
  logic [CODE_W-1:0]   glyph_nxt [NUM_DIGITS];
  logic                out_valid_r, out_valid_nxt;

  logic                adv;
  logic                in_take;
  logic                in_range;
  logic [CODE_W-1:0]   split_codes [NUM_DIGITS];

  assign adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || adv;

  swdm_digit_split u_split (
    .value    (s1_value_r),
    .in_range (in_range),
    .codes    (split_codes)
  );

  // Slot reload happens before the scan sees the codes.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      glyph_nxt[i] = (s1_show_r && in_range) ? split_codes[i] : glyph_r[i];
    end
  end

  swdm_scan u_scan (
    .codes (glyph_nxt),
    .cur   (st_r),
    .nxt   (st_nxt)
  );

  assign s1_valid_nxt  = in_take ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        glyph_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
        for (int i = 0; i < NUM_DIGITS; i++) begin
          glyph_r[i] <= glyph_nxt[i];
        end
      end
    end
  end

  // Tick payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_show_r  <= in_ch.show_number;
      s1_value_r <= in_ch.number_value;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.anode_pattern = st_r.anode;
  assign out_ch.digit_enable  = st_r.cathode;
  assign out_ch.active_slot   = st_r.slot;

  // At most one digit lit at any time.
  a_one_cathode : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(st_r.cathode))
    else $error("more than one cathode on");

  // Slot index stays within the digit range.
  a_slot_range : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.slot != SLOT_W'(3))
    else $error("slot index out of range");

  // Slot only moves on the tick that empties the dwell.
  a_slot_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && st_r.dwell != DWELL_W'(1)) |=> $stable(st_r.slot))
    else $error("slot moved before dwell expired");

  // State never changes while a result waits in a stall.
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(st_r))
    else $error("state changed during output stall");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted seven-segment display multiplexer.
// A cycle-level model of the display runs beside the block. Each accepted
// tick updates that model, and the frame it predicts (anodes, cathodes,
// selected slot) is queued. Every frame that leaves the block is checked
// against the oldest queued frame. Directed values come first, then random
// ticks under changing sender and receiver idle rates, then one long
// receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb;
  import swdm_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 5;
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;     // settle time after the last frame
  localparam int CYCLE_LIMIT  = 200000;

  // One displayed frame, as the result channel carries it.
  typedef struct packed {
    logic [SEG_W-1:0]      anode;
    logic [NUM_DIGITS-1:0] cathode;
    logic [SLOT_W-1:0]     slot;
  } frame_t;

  logic clk;
  logic rst_n;

  swdm_in_if  in_ch ();
  swdm_out_if out_ch ();

  segment_weighted_display_mux u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Display model state.
  logic [CODE_W-1:0]     slot_codes [NUM_DIGITS];
  logic [SLOT_W-1:0]     cur_slot;
  logic [DWELL_W-1:0]    dwell_left;
  logic [SEG_W-1:0]      anode_drive;
  logic [NUM_DIGITS-1:0] cathode_on;

  frame_t frames_due [$];   // predicted frames, oldest first
  int     mismatches = 0;
  int     cycle_cnt  = 0;

  // Idle rates in percent, changed per test.
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  logic   hold_req;

  // --------------------------------------------------------------------------
  // Display model
  // --------------------------------------------------------------------------
  function automatic void clear_display();
    for (int i = 0; i < NUM_DIGITS; i++) begin
      slot_codes[i] = '0;   // every slot powers up showing digit zero
    end
    cur_slot    = '0;
    dwell_left  = '0;       // first decrement wraps: 256 ticks to first move
    anode_drive = '0;
    cathode_on  = '0;
  endfunction

  // Segment pattern of a code; known is low for codes with no glyph.
  function automatic logic [SEG_W-1:0] segments_of(input logic [CODE_W-1:0] code,
                                                   output bit known);
    known = 1'b1;
    if (code <= 8'd9) begin
      return DIGIT_GLYPHS[code];
    end
    if (code >= LETTER_BASE && code <= LETTER_LAST) begin
      return LETTER_GLYPHS[code - LETTER_BASE];
    end
    known = 1'b0;
    return '0;
  endfunction

  // Apply one tick and return the frame shown after it.
  function automatic frame_t advance_display(input logic show,
                                             input logic [VALUE_W-1:0] val);
    logic [SEG_W-1:0] seg;
    bit               known;
    int               lit;
    frame_t           f;
    if (show && val <= MAX_VALUE) begin
      // leading zeros of hundreds and tens go blank; ones always shows
      slot_codes[0] = (val >= 100) ? CODE_W'(val / 100) : BLANK_CODE;
      slot_codes[1] = (val >= 10) ? CODE_W'((val / 10) % 10) : BLANK_CODE;
      slot_codes[2] = CODE_W'(val % 10);
    end
    dwell_left = dwell_left - 1'b1;
    if (dwell_left == 0) begin
      cur_slot = (cur_slot >= SLOT_W'(NUM_DIGITS - 1)) ? '0 : cur_slot + 1'b1;
      // Walk upward; a blank slot hands over to the next one in the same tick.
      for (int s = 0; s < NUM_DIGITS; s++) begin
        if (cur_slot != SLOT_W'(s)) continue;
        seg = segments_of(slot_codes[s], known);
        lit = known ? $countones(seg) : 0;
        if (lit == 0) begin
          cathode_on[s] = 1'b0;
          if (s < NUM_DIGITS - 1) cur_slot = SLOT_W'(s + 1);
          else                    dwell_left = 1;
        end else begin
          anode_drive   = seg;
          cathode_on    = '0;
          cathode_on[s] = 1'b1;
          dwell_left    = DWELL_W'(lit);   // fewer segments, shorter dwell
        end
      end
    end
    f.anode   = anode_drive;
    f.cathode = cathode_on;
    f.slot    = cur_slot;
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("FAIL segment_weighted_display_mux");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: check each transfer, then pick the next ready.
  // Signals read right after the edge hold their pre-edge values.
  // --------------------------------------------------------------------------
  initial begin
    int     hold_left;
    frame_t want;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected frame anode=%h cathode=%b slot=%0d", $time,
                   out_ch.anode_pattern, out_ch.digit_enable, out_ch.active_slot);
        end else begin
          want = frames_due.pop_front();
          if (out_ch.anode_pattern !== want.anode) begin
            mismatches++;
            $display("%0t: anode_pattern expected %h actual %h", $time,
                     want.anode, out_ch.anode_pattern);
          end
          if (out_ch.digit_enable !== want.cathode) begin
            mismatches++;
            $display("%0t: digit_enable expected %b actual %b", $time,
                     want.cathode, out_ch.digit_enable);
          end
          if (out_ch.active_slot !== want.slot) begin
            mismatches++;
            $display("%0t: active_slot expected %0d actual %0d", $time,
                     want.slot, out_ch.active_slot);
          end
        end
      end
      // ready: long hold-off when asked, else random idling
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_left    = HOLD_CYCLES - 1;
        hold_req     <= 1'b0;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tick sender: optional idle gap, then hold the tick until it transfers.
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic show, input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.show_number  <= show;
    in_ch.number_value <= val;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    frames_due.push_back(advance_display(show, val));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, leading-zero blanking, out-of-range and no-refresh ticks.
  task automatic test_directed_values();
    logic [VALUE_W:0] cases [] = '{
      {1'b1, 16'd0},     {1'b1, 16'd999},   {1'b1, 16'd1000},  {1'b1, 16'hFFFF},
      {1'b0, 16'd0},     {1'b0, 16'hFFFF},  {1'b1, 16'd1},     {1'b1, 16'd9},
      {1'b1, 16'd10},    {1'b1, 16'd99},    {1'b1, 16'd100},   {1'b1, 16'd909},
      {1'b1, 16'd90},    {1'b1, 16'd500},   {1'b0, 16'd123},   {1'b1, 16'h8000},
      {1'b1, 16'h5555},  {1'b1, 16'hAAAA},  {1'b1, 16'd888},   {1'b1, 16'd7},
      {1'b1, 16'd111},   {1'b0, 16'd1},     {1'b1, 16'd5}
    };
    foreach (cases[i]) begin
      send_tick(cases[i][VALUE_W], cases[i][VALUE_W-1:0]);
    end
  endtask

  // Random ticks; a value often repeats so the slot walk runs over a stable
  // number, including one- and two-digit values with blank slots to skip.
  task automatic test_random_ticks(input int count);
    logic               show;
    logic [VALUE_W-1:0] val;
    int                 pick;
    show = 1'b1;
    val  = '0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) >= 50) begin
        pick = $urandom_range(99);
        show = 1'b1;
        if (pick < 10) begin
          show = 1'b0;
          val  = VALUE_W'($urandom);
        end else if (pick < 20) val = VALUE_W'($urandom_range(65535, 1000));
        else if (pick < 40)     val = VALUE_W'($urandom_range(9));
        else if (pick < 60)     val = VALUE_W'($urandom_range(99, 10));
        else                    val = VALUE_W'($urandom_range(999, 100));
      end
      send_tick(show, val);
    end
  endtask

  // Receiver stops for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    hold_req <= 1'b1;
    for (int n = 0; n < 30; n++) begin
      send_tick(1'b1, VALUE_W'($urandom_range(999)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.show_number  <= 1'b0;
    in_ch.number_value <= '0;
    hold_req           <= 1'b0;
    rst_n              <= 1'b0;
    clear_display();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 6;
    rx_idle_pct = 71;
    test_directed_values();
    test_random_ticks(300);

    tx_idle_pct = 71;
    rx_idle_pct = 6;
    test_random_ticks(300);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_ticks(300);
    test_backpressure();

    in_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS segment_weighted_display_mux");
    end else begin
      $display("FAIL segment_weighted_display_mux");
    end
    $finish;
  end

endmodule
